FILE: design/alee_pkg.sv
// Shared constants, codes and command/status types for the array list edit engine.
package alee_pkg;

  localparam int DEPTH   = 1024;
  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int ACT_W   = 5;
  localparam int POS_W   = 12;
  localparam int AMT_W   = 16;
  localparam int STAT_W  = 3;
  localparam int FOUND_W = 10;
  localparam int COUNT_W = 11;
  localparam int CMP_W   = 18;
  localparam int SW      = CW + 2;
  localparam int MOD_W   = CW + 1;
  localparam int BIT_W   = $clog2(AMT_W);

  typedef enum logic [ACT_W-1:0] {
    ACT_SET_LEN    = 5'd0,
    ACT_WRITE      = 5'd1,
    ACT_FILL_SAME  = 5'd2,
    ACT_FILL_SEQ   = 5'd3,
    ACT_DEL_IDX    = 5'd4,
    ACT_DEL_VAL    = 5'd5,
    ACT_DEL_RANGE  = 5'd6,
    ACT_INS_IDX    = 5'd7,
    ACT_INS_SORTED = 5'd8,
    ACT_READ       = 5'd9,
    ACT_MAX        = 5'd10,
    ACT_MIN        = 5'd11,
    ACT_LIN_SEARCH = 5'd12,
    ACT_BIN_SEARCH = 5'd13,
    ACT_IS_ASC     = 5'd14,
    ACT_IS_DESC    = 5'd15,
    ACT_ALL_EQ     = 5'd16,
    ACT_SORT       = 5'd17,
    ACT_REVERSE    = 5'd18,
    ACT_ROT_LEFT   = 5'd19,
    ACT_ROT_RIGHT  = 5'd20,
    ACT_NOP        = 5'd21
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_BOUNDS  = 3'd1,
    ST_FULL    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

  typedef enum logic [5:0] {
    OP_NONE, OP_LATCH, OP_CLR, OP_SETLEN, OP_STATUS, OP_WRITE, OP_RD_POS, OP_ELEM_RD,
    OP_FILL_INIT, OP_FILL_STEP, OP_COPY_INIT, OP_RD_I, OP_COPY_WR, OP_COPY_END,
    OP_SCAN_INIT, OP_INC_I, OP_SHIFT_INIT, OP_RD_IM1, OP_SHIFT_WR, OP_INS_WR,
    OP_ACC_LOAD, OP_ACC_UPD, OP_FOUND, OP_BS_INIT, OP_RD_MID, OP_BS_UPD,
    OP_ORD_NEXT, OP_PRED_SET, OP_SORT_INIT, OP_SORT_T, OP_RD_JM1, OP_SORT_MOVE,
    OP_SORT_PUT, OP_SEG_ALL, OP_SEG_LO, OP_SEG_HI, OP_REV_T, OP_REV_W1, OP_REV_W2,
    OP_MOD_INIT, OP_MOD_STEP, OP_K_SET, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    action_t act;
    logic    pos_lt_n;
    logic    pos_le_n;
    logic    range_ok;
    logic    full;
    logic    empty;
    logic    n_lt2;
    logic    i_lt_n;
    logic    i_gt_p;
    logic    j_gt0;
    logic    rd_lt_val;
    logic    rd_eq_val;
    logic    t_lt_rd;
    logic    ord_bad;
    logic    lo_le_hi;
    logic    rev_more;
    logic    mod_last;
    logic    clr_last;
    logic    out_free;
  } dp_stat_t;

  typedef enum logic [5:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_READ_WAIT, S_FILL, S_COPY_RD, S_COPY_WR,
    S_SCAN_RD, S_SCAN_CHK, S_SHIFT_RD, S_SHIFT_WR, S_MM_RD0, S_MM_LOAD, S_MM_RD,
    S_MM_UPD, S_LS_RD, S_LS_CHK, S_BS_RD, S_BS_CHK, S_ORD_RD0, S_ORD_LOAD, S_ORD_RD,
    S_ORD_CHK, S_SORT_RD, S_SORT_T, S_SORT_RDJ, S_SORT_CHK, S_MOD, S_KSET, S_SEG,
    S_REV_RD, S_REV_T, S_REV_W1, S_REV_W2, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    SEG_ALL,
    SEG_LO,
    SEG_HI
  } seg_t;

endpackage

FILE: design/alee_ram.sv
// Generic single-write, single-read RAM with registered read data.
module alee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/alee_ctrl.sv
// Controller state machine: sequences datapath operations for each request.
module alee_ctrl
  import alee_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t st,
  output dp_cmd_t  cmd
);

  state_t state, state_next;
  seg_t   seg, seg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      seg   <= SEG_ALL;
    end else begin
      state <= state_next;
      seg   <= seg_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    seg_next   = seg;
    case (state)
      S_CLEAR:     if (st.clr_last) state_next = S_IDLE;
      S_IDLE:      if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        state_next = S_DONE;
        case (st.act)
          ACT_READ:      if (st.pos_lt_n) state_next = S_READ_WAIT;
          ACT_FILL_SAME,
          ACT_FILL_SEQ:  state_next = S_FILL;
          ACT_DEL_IDX:   if (st.pos_lt_n) state_next = S_COPY_RD;
          ACT_DEL_VAL:   state_next = S_COPY_RD;
          ACT_DEL_RANGE: if (st.range_ok) state_next = S_COPY_RD;
          ACT_INS_IDX:   if (st.pos_le_n && !st.full) state_next = S_SHIFT_RD;
          ACT_INS_SORTED: if (!st.full) state_next = S_SCAN_RD;
          ACT_MAX,
          ACT_MIN:       if (!st.empty) state_next = S_MM_RD0;
          ACT_LIN_SEARCH: state_next = S_LS_RD;
          ACT_BIN_SEARCH: state_next = S_BS_RD;
          ACT_IS_ASC,
          ACT_IS_DESC,
          ACT_ALL_EQ:    if (!st.n_lt2) state_next = S_ORD_RD0;
          ACT_SORT:      state_next = S_SORT_RD;
          ACT_REVERSE: begin
            state_next = S_SEG;
            seg_next   = SEG_ALL;
          end
          ACT_ROT_LEFT,
          ACT_ROT_RIGHT: if (!st.empty) state_next = S_MOD;
          default:       state_next = S_DONE;
        endcase
      end
      S_READ_WAIT: state_next = S_DONE;
      S_FILL:      if (!st.i_lt_n) state_next = S_DONE;
      S_COPY_RD:   state_next = st.i_lt_n ? S_COPY_WR : S_DONE;
      S_COPY_WR:   state_next = S_COPY_RD;
      S_SCAN_RD:   state_next = st.i_lt_n ? S_SCAN_CHK : S_SHIFT_RD;
      S_SCAN_CHK:  state_next = st.rd_lt_val ? S_SCAN_RD : S_SHIFT_RD;
      S_SHIFT_RD:  state_next = st.i_gt_p ? S_SHIFT_WR : S_DONE;
      S_SHIFT_WR:  state_next = S_SHIFT_RD;
      S_MM_RD0:    state_next = S_MM_LOAD;
      S_MM_LOAD:   state_next = S_MM_RD;
      S_MM_RD:     state_next = st.i_lt_n ? S_MM_UPD : S_DONE;
      S_MM_UPD:    state_next = S_MM_RD;
      S_LS_RD:     state_next = st.i_lt_n ? S_LS_CHK : S_DONE;
      S_LS_CHK:    state_next = st.rd_eq_val ? S_DONE : S_LS_RD;
      S_BS_RD:     state_next = st.lo_le_hi ? S_BS_CHK : S_DONE;
      S_BS_CHK:    state_next = st.rd_eq_val ? S_DONE : S_BS_RD;
      S_ORD_RD0:   state_next = S_ORD_LOAD;
      S_ORD_LOAD:  state_next = S_ORD_RD;
      S_ORD_RD:    state_next = st.i_lt_n ? S_ORD_CHK : S_DONE;
      S_ORD_CHK:   state_next = st.ord_bad ? S_DONE : S_ORD_RD;
      S_SORT_RD:   state_next = st.i_lt_n ? S_SORT_T : S_DONE;
      S_SORT_T:    state_next = S_SORT_RDJ;
      S_SORT_RDJ:  state_next = st.j_gt0 ? S_SORT_CHK : S_SORT_RD;
      S_SORT_CHK:  state_next = st.t_lt_rd ? S_SORT_RDJ : S_SORT_RD;
      S_MOD:       if (st.mod_last) state_next = S_KSET;
      S_KSET: begin
        state_next = S_SEG;
        seg_next   = SEG_LO;
      end
      S_SEG:       state_next = S_REV_RD;
      S_REV_RD: begin
        if (st.rev_more) begin
          state_next = S_REV_T;
        end else begin
          case (seg)
            SEG_LO: begin
              state_next = S_SEG;
              seg_next   = SEG_HI;
            end
            SEG_HI: begin
              state_next = S_SEG;
              seg_next   = SEG_ALL;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_REV_T:     state_next = S_REV_W1;
      S_REV_W1:    state_next = S_REV_W2;
      S_REV_W2:    state_next = S_REV_RD;
      S_DONE:      if (st.out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // datapath command
  always_comb begin
    cmd.op   = OP_NONE;
    cmd.code = ST_OK;
    case (state)
      S_CLEAR: cmd.op = OP_CLR;
      S_IDLE:  if (in_valid) cmd.op = OP_LATCH;
      S_DISPATCH: begin
        case (st.act)
          ACT_SET_LEN: cmd.op = OP_SETLEN;
          ACT_WRITE: begin
            cmd.op   = st.pos_lt_n ? OP_WRITE : OP_STATUS;
            cmd.code = ST_BOUNDS;
          end
          ACT_READ: begin
            cmd.op   = st.pos_lt_n ? OP_RD_POS : OP_STATUS;
            cmd.code = ST_BOUNDS;
          end
          ACT_FILL_SAME,
          ACT_FILL_SEQ: cmd.op = OP_FILL_INIT;
          ACT_DEL_IDX: begin
            cmd.op   = st.pos_lt_n ? OP_COPY_INIT : OP_STATUS;
            cmd.code = ST_BOUNDS;
          end
          ACT_DEL_VAL: cmd.op = OP_COPY_INIT;
          ACT_DEL_RANGE: begin
            cmd.op   = st.range_ok ? OP_COPY_INIT : OP_STATUS;
            cmd.code = ST_BOUNDS;
          end
          ACT_INS_IDX: begin
            if (!st.pos_le_n) begin
              cmd.op   = OP_STATUS;
              cmd.code = ST_BOUNDS;
            end else if (st.full) begin
              cmd.op   = OP_STATUS;
              cmd.code = ST_FULL;
            end else begin
              cmd.op = OP_SHIFT_INIT;
            end
          end
          ACT_INS_SORTED: begin
            cmd.op   = st.full ? OP_STATUS : OP_SCAN_INIT;
            cmd.code = ST_FULL;
          end
          ACT_MAX,
          ACT_MIN: begin
            cmd.op   = st.empty ? OP_STATUS : OP_SCAN_INIT;
            cmd.code = ST_EMPTY;
          end
          ACT_LIN_SEARCH: cmd.op = OP_SCAN_INIT;
          ACT_BIN_SEARCH: cmd.op = OP_BS_INIT;
          ACT_IS_ASC,
          ACT_IS_DESC,
          ACT_ALL_EQ: cmd.op = st.n_lt2 ? OP_PRED_SET : OP_SCAN_INIT;
          ACT_SORT: cmd.op = OP_SORT_INIT;
          ACT_ROT_LEFT,
          ACT_ROT_RIGHT: if (!st.empty) cmd.op = OP_MOD_INIT;
          default: cmd.op = OP_NONE;
        endcase
      end
      S_READ_WAIT: cmd.op = OP_ELEM_RD;
      S_FILL:      if (st.i_lt_n) cmd.op = OP_FILL_STEP;
      S_COPY_RD:   cmd.op = st.i_lt_n ? OP_RD_I : OP_COPY_END;
      S_COPY_WR:   cmd.op = OP_COPY_WR;
      S_SCAN_RD:   cmd.op = st.i_lt_n ? OP_RD_I : OP_SHIFT_INIT;
      S_SCAN_CHK:  cmd.op = st.rd_lt_val ? OP_INC_I : OP_SHIFT_INIT;
      S_SHIFT_RD:  cmd.op = st.i_gt_p ? OP_RD_IM1 : OP_INS_WR;
      S_SHIFT_WR:  cmd.op = OP_SHIFT_WR;
      S_MM_RD0:    cmd.op = OP_RD_I;
      S_MM_LOAD:   cmd.op = OP_ACC_LOAD;
      S_MM_RD:     if (st.i_lt_n) cmd.op = OP_RD_I;
      S_MM_UPD:    cmd.op = OP_ACC_UPD;
      S_LS_RD: begin
        cmd.op   = st.i_lt_n ? OP_RD_I : OP_STATUS;
        cmd.code = ST_MISSING;
      end
      S_LS_CHK:    cmd.op = st.rd_eq_val ? OP_FOUND : OP_INC_I;
      S_BS_RD: begin
        cmd.op   = st.lo_le_hi ? OP_RD_MID : OP_STATUS;
        cmd.code = ST_MISSING;
      end
      S_BS_CHK:    cmd.op = st.rd_eq_val ? OP_FOUND : OP_BS_UPD;
      S_ORD_RD0:   cmd.op = OP_RD_I;
      S_ORD_LOAD:  cmd.op = OP_ORD_NEXT;
      S_ORD_RD:    cmd.op = st.i_lt_n ? OP_RD_I : OP_PRED_SET;
      S_ORD_CHK:   if (!st.ord_bad) cmd.op = OP_ORD_NEXT;
      S_SORT_RD:   if (st.i_lt_n) cmd.op = OP_RD_I;
      S_SORT_T:    cmd.op = OP_SORT_T;
      S_SORT_RDJ:  cmd.op = st.j_gt0 ? OP_RD_JM1 : OP_SORT_PUT;
      S_SORT_CHK:  cmd.op = st.t_lt_rd ? OP_SORT_MOVE : OP_SORT_PUT;
      S_MOD:       cmd.op = OP_MOD_STEP;
      S_KSET:      cmd.op = OP_K_SET;
      S_SEG: begin
        case (seg)
          SEG_LO:  cmd.op = OP_SEG_LO;
          SEG_HI:  cmd.op = OP_SEG_HI;
          default: cmd.op = OP_SEG_ALL;
        endcase
      end
      S_REV_RD:    if (st.rev_more) cmd.op = OP_RD_I;
      S_REV_T:     cmd.op = OP_REV_T;
      S_REV_W1:    cmd.op = OP_REV_W1;
      S_REV_W2:    cmd.op = OP_REV_W2;
      S_DONE:      if (st.out_free) cmd.op = OP_EMIT;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

FILE: design/alee_dp.sv
// Datapath: element store, count, index registers, compare logic and result register.
module alee_dp
  import alee_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  output dp_stat_t                 st,
  input  logic [ACT_W-1:0]         action,
  input  logic [POS_W-1:0]         position,
  input  logic [POS_W-1:0]         range_end,
  input  logic signed [DATA_W-1:0] operand_value,
  input  logic signed [DATA_W-1:0] seq_step,
  input  logic [AMT_W-1:0]         amount,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [STAT_W-1:0]        status,
  output logic signed [DATA_W-1:0] element,
  output logic [FOUND_W-1:0]       found_at,
  output logic                     predicate,
  output logic [COUNT_W-1:0]       count
);

  action_t                  act;
  logic [POS_W-1:0]         pos;
  logic [POS_W-1:0]         rend;
  logic signed [DATA_W-1:0] val;
  logic signed [DATA_W-1:0] step;
  logic [AMT_W-1:0]         amt;

  logic [CW-1:0]            n;
  logic [CW-1:0]            i;
  logic [CW-1:0]            j;
  logic [CW-1:0]            p;
  logic [CW-1:0]            k;
  logic signed [DATA_W-1:0] t;
  logic signed [SW-1:0]     lo;
  logic signed [SW-1:0]     hi;
  logic [MOD_W-1:0]         r;
  logic [BIT_W-1:0]         bitc;

  status_t                  res_status;
  logic signed [DATA_W-1:0] res_elem;
  logic [FOUND_W-1:0]       res_found;
  logic                     res_pred;

  logic                     we;
  logic [CW-1:0]            w_idx;
  logic [DATA_W-1:0]        wdata;
  logic [CW-1:0]            r_idx;
  logic [DATA_W-1:0]        rdata_raw;
  logic signed [DATA_W-1:0] rdata;

  logic [CMP_W-1:0]         pos_c, rend_c, amt_c, n_c, i_c, j_c;
  logic signed [SW-1:0]     mid_sum;
  logic [SW-1:0]            mid;
  logic [MOD_W-1:0]         r_sh;
  logic [MOD_W-1:0]         r_new;
  logic [CW-1:0]            im1;
  logic [CW-1:0]            jm1;
  logic                     keep;
  logic                     acc_take;

  alee_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (w_idx[AW-1:0]),
    .wdata (wdata),
    .raddr (r_idx[AW-1:0]),
    .rdata (rdata_raw)
  );

  assign rdata  = $signed(rdata_raw);
  assign pos_c  = CMP_W'(pos);
  assign rend_c = CMP_W'(rend);
  assign amt_c  = CMP_W'(amt);
  assign n_c    = CMP_W'(n);
  assign i_c    = CMP_W'(i);
  assign j_c    = CMP_W'(j);
  assign im1    = i - CW'(1);
  assign jm1    = j - CW'(1);

  assign mid_sum = lo + hi;
  assign mid     = SW'(mid_sum >>> 1);

  // one restoring remainder step per cycle, MSB of the amount first
  assign r_sh  = {r[MOD_W-2:0], amt[bitc]};
  assign r_new = (r_sh >= MOD_W'(n)) ? r_sh - MOD_W'(n) : r_sh;

  assign keep     = !((act == ACT_DEL_VAL) && (rdata == val));
  assign acc_take = (act == ACT_MAX) ? (res_elem < rdata) : (rdata < res_elem);

  always_comb begin
    st.act       = act;
    st.pos_lt_n  = pos_c < n_c;
    st.pos_le_n  = pos_c <= n_c;
    st.range_ok  = (pos_c <= rend_c) && (rend_c < n_c);
    st.full      = n_c >= CMP_W'(DEPTH);
    st.empty     = (n == '0);
    st.n_lt2     = n_c < CMP_W'(2);
    st.i_lt_n    = i_c < n_c;
    st.i_gt_p    = i > p;
    st.j_gt0     = (j != '0);
    st.rd_lt_val = rdata < val;
    st.rd_eq_val = (rdata == val);
    st.t_lt_rd   = t < rdata;
    case (act)
      ACT_IS_ASC:  st.ord_bad = rdata < t;
      ACT_IS_DESC: st.ord_bad = t < rdata;
      default:     st.ord_bad = (t != rdata);
    endcase
    st.lo_le_hi  = lo <= hi;
    st.rev_more  = (i_c + CMP_W'(1)) < j_c;
    st.mod_last  = (bitc == '0);
    st.clr_last  = (i == CW'(DEPTH - 1));
    st.out_free  = !out_valid || out_ready;
  end

  // store ports
  always_comb begin
    we    = 1'b0;
    w_idx = i;
    wdata = t;
    r_idx = i;
    case (cmd.op)
      OP_CLR: begin
        we    = 1'b1;
        wdata = '0;
      end
      OP_WRITE: begin
        we    = 1'b1;
        w_idx = CW'(pos);
        wdata = val;
      end
      OP_RD_POS:    r_idx = CW'(pos);
      OP_FILL_STEP: we = 1'b1;
      OP_COPY_WR: begin
        we    = keep;
        w_idx = j;
        wdata = rdata;
      end
      OP_RD_IM1:    r_idx = im1;
      OP_SHIFT_WR: begin
        we    = 1'b1;
        wdata = rdata;
      end
      OP_INS_WR: begin
        we    = 1'b1;
        w_idx = p;
        wdata = val;
      end
      OP_RD_MID:    r_idx = CW'(mid);
      OP_RD_JM1:    r_idx = jm1;
      OP_SORT_MOVE: begin
        we    = 1'b1;
        w_idx = j;
        wdata = rdata;
      end
      OP_SORT_PUT: begin
        we    = 1'b1;
        w_idx = j;
      end
      OP_REV_T:     r_idx = jm1;
      OP_REV_W1: begin
        we    = 1'b1;
        wdata = rdata;
      end
      OP_REV_W2: begin
        we    = 1'b1;
        w_idx = jm1;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n         <= '0;
      i         <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop the beat once taken, unless a new one is loaded this cycle
      if (out_valid && out_ready && cmd.op != OP_EMIT) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_LATCH: begin
          act        <= action_t'(action);
          pos        <= position;
          rend       <= range_end;
          val        <= operand_value;
          step       <= seq_step;
          amt        <= amount;
          res_status <= ST_OK;
          res_elem   <= '0;
          res_found  <= '0;
          res_pred   <= 1'b0;
        end
        OP_CLR: i <= i + CW'(1);
        OP_SETLEN: begin
          if (amt_c > CMP_W'(DEPTH)) begin
            n          <= CW'(DEPTH);
            res_status <= ST_BOUNDS;
          end else begin
            n <= CW'(amt);
          end
        end
        OP_STATUS:    res_status <= cmd.code;
        OP_ELEM_RD:   res_elem <= rdata;
        OP_FILL_INIT: begin
          i <= '0;
          t <= val;
        end
        OP_FILL_STEP: begin
          t <= t + ((act == ACT_FILL_SEQ) ? step : '0);
          i <= i + CW'(1);
        end
        OP_COPY_INIT: begin
          case (act)
            ACT_DEL_IDX: begin
              i <= CW'(pos) + CW'(1);
              j <= CW'(pos);
            end
            ACT_DEL_RANGE: begin
              i <= CW'(rend) + CW'(1);
              j <= CW'(pos);
            end
            default: begin
              i <= '0;
              j <= '0;
            end
          endcase
        end
        OP_COPY_WR: begin
          if (keep) begin
            j <= j + CW'(1);
          end
          i <= i + CW'(1);
        end
        OP_COPY_END:  n <= j;
        OP_SCAN_INIT: i <= '0;
        OP_INC_I:     i <= i + CW'(1);
        OP_SHIFT_INIT: begin
          p <= (act == ACT_INS_IDX) ? CW'(pos) : i;
          i <= n;
        end
        OP_SHIFT_WR:  i <= im1;
        OP_INS_WR:    n <= n + CW'(1);
        OP_ACC_LOAD: begin
          res_elem <= rdata;
          i        <= i + CW'(1);
        end
        OP_ACC_UPD: begin
          if (acc_take) begin
            res_elem <= rdata;
          end
          i <= i + CW'(1);
        end
        OP_FOUND: begin
          res_found  <= FOUND_W'(i);
          res_status <= ST_OK;
        end
        OP_BS_INIT: begin
          lo <= '0;
          hi <= SW'(n) - SW'(1);
        end
        OP_RD_MID:    i <= CW'(mid);
        OP_BS_UPD: begin
          if (rdata < val) begin
            lo <= SW'(i) + SW'(1);
          end else begin
            hi <= SW'(i) - SW'(1);
          end
        end
        OP_ORD_NEXT: begin
          t <= rdata;
          i <= i + CW'(1);
        end
        OP_PRED_SET:  res_pred <= 1'b1;
        OP_SORT_INIT: i <= CW'(1);
        OP_SORT_T: begin
          t <= rdata;
          j <= i;
        end
        OP_SORT_MOVE: j <= jm1;
        OP_SORT_PUT:  i <= i + CW'(1);
        OP_SEG_ALL: begin
          i <= '0;
          j <= n;
        end
        OP_SEG_LO: begin
          i <= '0;
          j <= k;
        end
        OP_SEG_HI: begin
          i <= k;
          j <= n;
        end
        OP_REV_T:     t <= rdata;
        OP_REV_W2: begin
          i <= i + CW'(1);
          j <= jm1;
        end
        OP_MOD_INIT: begin
          r    <= '0;
          bitc <= BIT_W'(AMT_W - 1);
        end
        OP_MOD_STEP: begin
          r    <= r_new;
          bitc <= bitc - BIT_W'(1);
        end
        OP_K_SET: begin
          if (act == ACT_ROT_LEFT || r == '0) begin
            k <= CW'(r);
          end else begin
            k <= n - CW'(r);
          end
        end
        OP_EMIT: begin
          out_valid <= 1'b1;
          status    <= res_status;
          element   <= res_elem;
          found_at  <= res_found;
          predicate <= res_pred;
          count     <= COUNT_W'(n);
        end
        default: begin
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    n_c <= CMP_W'(DEPTH))
    else $error("element count above store size");

  a_mid_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_RD_MID) |-> (CMP_W'(mid) < n_c))
    else $error("binary search probe outside used elements");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (we && cmd.op != OP_CLR) |-> (CMP_W'(w_idx) <= n_c && CMP_W'(w_idx) < CMP_W'(DEPTH)))
    else $error("store write beyond used elements");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_EMIT) |=> out_valid)
    else $error("result beat not presented after emit");

endmodule

FILE: design/array_list_edit_engine.sv
// Top level of the array list edit engine: controller plus datapath.
//
// Requests arrive on the input channel (in_valid/in_ready) as one beat carrying
// action, position, range_end, operand_value, seq_step and amount. Each request
// yields exactly one result beat on the output channel (out_valid/out_ready)
// carrying status, element, found_at, predicate and count.
// After reset the store of 1024 elements is swept to zero, one entry per cycle:
// in_ready stays low until the sweep ends, and the count starts at zero.
// One request is worked at a time. Elements live in a RAM with one write and one
// registered read per cycle, and that port pair sets the cost: walks over the
// used elements (shift/insert, delete, search, order tests, max/min, fill) go
// one element at a time, binary search one probe at a time, reverse one element
// pair at a time, rotate first reduces the amount modulo the count bit by bit
// and then reverses segments, and sort moves one element at a time, with at
// most n*n moves in the worst case.
// The result sits in an output register; a new request is taken while it waits.
// If the receiver stalls, a finished second result holds the engine until the
// first beat is taken.
module array_list_edit_engine
  import alee_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [ACT_W-1:0]         action,
  input  logic [POS_W-1:0]         position,
  input  logic [POS_W-1:0]         range_end,
  input  logic signed [DATA_W-1:0] operand_value,
  input  logic signed [DATA_W-1:0] seq_step,
  input  logic [AMT_W-1:0]         amount,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        status,
  output logic signed [DATA_W-1:0] element,
  output logic [FOUND_W-1:0]       found_at,
  output logic                     predicate,
  output logic [COUNT_W-1:0]       count
);

  dp_cmd_t  cmd;
  dp_stat_t st;

  alee_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  alee_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .action        (action),
    .position      (position),
    .range_end     (range_end),
    .operand_value (operand_value),
    .seq_step      (seq_step),
    .amount        (amount),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .status        (status),
    .element       (element),
    .found_at      (found_at),
    .predicate     (predicate),
    .count         (count)
  );

endmodule
